>>> hdl/rtdc_pkg.sv
package rtdc_pkg;

  // Field widths of the stream items.
  localparam int CODE_W = 16;
  localparam int TEMP_W = 16;

  // Reference mode codes.
  localparam logic MODE_EXT = 1'b0;
  localparam logic MODE_INT = 1'b1;

  // Resistance scaling: |code| times gain, then 16 fractional bits, then divided by full scale.
  localparam int GAIN_EXT   = 195;
  localparam int GAIN_SHIFT = 12;
  localparam int Y_W        = 28;
  localparam int RFRAC_W    = 16;
  localparam int RDIV_W     = Y_W + RFRAC_W;
  localparam int RDIV_STEPS = 4;
  localparam int R_OFFSET   = 80609;

  // Scaled discriminant Dn = DN_BASE - DN_SLOPE * r.
  localparam int                 DN_W     = 64;
  localparam logic signed [63:0] DN_BASE  = 64'sd1758480889 * 64'sd6553600;
  localparam logic signed [28:0] DN_SLOPE = 29'sd231000000;

  // Square root: 56 root bits, radicand padded with 48 zero bits for 24 fractional bits.
  localparam int SQ_ITER  = 56;
  localparam int SQ_STEPS = 4;
  localparam int SQ_PAD   = 48;

  // Numerator of the temperature and the limit for the below-minimum flag.
  localparam logic [SQ_ITER-1:0] NUM_BASE  = SQ_ITER'(64'd100052480 << 24);
  localparam logic [SQ_ITER-1:0] BELOW_LIM = SQ_ITER'(64'd103009280 << 24);

  // Degree divisor 29568 * 2^24 = 231 * 2^31.
  localparam int SCALE_W    = 63;
  localparam int TDIV_SHIFT = 31;
  localparam int TDIV_W     = SCALE_W - TDIV_SHIFT;
  localparam int DEG_DIV    = 231;
  localparam int DEG_DIV_W  = 8;
  localparam int TDIV_STEPS = 4;

  // Saturation limits.
  localparam logic [TDIV_W-1:0]        POS_LIMIT = TDIV_W'(32767);
  localparam logic [TDIV_W-1:0]        NEG_LIMIT = TDIV_W'(32768);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN  = 16'sh8000;

  // Side information carried alongside the resistance divider.
  typedef struct packed {
    logic mode;
    logic neg;
  } rdiv_side_t;

  // Side information carried alongside the square root.
  typedef struct packed {
    logic mode;
    logic dn_neg;
  } sq_side_t;

  // Side information carried alongside the degree divider.
  typedef struct packed {
    logic neg;
    logic below;
    logic dn_neg;
  } tdiv_side_t;

  // One result item.
  typedef struct packed {
    logic                     range_error;
    logic                     below_minimum;
    logic signed [TEMP_W-1:0] temperature;
  } res_t;

endpackage

>>> hdl/rtd_code_to_temperature_unit.sv
// Channel   | Direction | Signals                          | Contents
// s_axis    | in        | s_tvalid, s_tready, s_tdata[15:0] | raw converter code
// m_axis    | out       | m_tvalid, m_tready, m_tdata[15:0] | temperature, flags in m_tuser
// config    | in        | cfg_we, cfg_wdata                 | reference mode
//
// One item is taken every cycle while the output buffer has a free entry.
// The pipeline is built mainly from the resistance divider (11 stages), the square root
// (14 stages) and the degree divider (8 stages), each resolving four bits per stage.
// Reset is synchronous and clears the pipeline valid bits, the output buffer and the mode.
// A two-entry output buffer lets input transfers continue while one result waits; the whole
// pipeline holds only when both entries are occupied.
module rtd_code_to_temperature_unit #(
  parameter int CODE_FULL_SCALE = 32767
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] raw_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] temperature
  output logic [1:0]  m_tuser,   // [0] below_minimum, [1] range_error
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int          FS_W  = $clog2(CODE_FULL_SCALE + 1);
  localparam longint      Q_MAX = (64'sd1 <<< (rtdc_pkg::RDIV_W - 1)) / CODE_FULL_SCALE;
  localparam int          QW    = $clog2(Q_MAX + 1);
  localparam int          RSW   = QW + 2;
  localparam int          PW    = RSW + 29;

  logic advance;
  logic buf_full;
  logic ref_mode;

  // Input stage.
  logic                          a_valid;
  logic [rtdc_pkg::RDIV_W-1:0]   a_dvd;
  rtdc_pkg::rdiv_side_t          a_side;
  logic signed [rtdc_pkg::CODE_W-1:0] code;
  logic                          code_neg;
  logic [rtdc_pkg::CODE_W-1:0]   code_mag;
  logic [rtdc_pkg::Y_W-1:0]      code_y;

  // Resistance divider outputs.
  logic                          rd_valid;
  logic [rtdc_pkg::RDIV_W-1:0]   rd_quo;
  rtdc_pkg::rdiv_side_t          rd_side;

  // Resistance and discriminant stages.
  logic                          c_valid;
  logic signed [RSW-1:0]         c_r;
  logic                          c_mode;
  logic signed [RSW-1:0]         r_mag;
  logic signed [RSW-1:0]         r_signed;
  logic                          d_valid;
  logic signed [rtdc_pkg::DN_W-1:0] d_dn;
  logic                          d_mode;
  logic signed [PW-1:0]          dn_prod;
  logic signed [rtdc_pkg::DN_W-1:0] dn_val;
  logic [2*rtdc_pkg::SQ_ITER-1:0] sq_rad;
  rtdc_pkg::sq_side_t            sq_in_side;

  // Square root outputs.
  logic                          sq_valid;
  logic [rtdc_pkg::SQ_ITER-1:0]  sq_root;
  rtdc_pkg::sq_side_t            sq_side;

  // Numerator stages.
  logic                          e_valid;
  logic [rtdc_pkg::SQ_ITER-1:0]  e_mag;
  logic                          e_mode;
  rtdc_pkg::tdiv_side_t          e_side;
  logic                          f_valid;
  logic [rtdc_pkg::TDIV_W-1:0]   f_dvd;
  rtdc_pkg::tdiv_side_t          f_side;
  logic [rtdc_pkg::SCALE_W-1:0]  scaled;
  logic [rtdc_pkg::SCALE_W-1:0]  mag_ext;

  // Degree divider outputs and the finished result.
  logic                          td_valid;
  logic [rtdc_pkg::TDIV_W-1:0]   td_quo;
  rtdc_pkg::tdiv_side_t          td_side;
  rtdc_pkg::res_t                res;
  rtdc_pkg::res_t                out_item;

  assign advance  = !buf_full;
  assign s_tready = advance;

  // Reference mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mode <= rtdc_pkg::MODE_EXT;
    end else if (cfg_we) begin
      ref_mode <= cfg_wdata;
    end
  end

  // Magnitude of the code times the mode gain, with 16 fractional bits appended.
  always_comb begin
    code     = $signed(s_tdata);
    code_neg = code[rtdc_pkg::CODE_W-1];
    code_mag = code_neg ? rtdc_pkg::CODE_W'(-code) : rtdc_pkg::CODE_W'(code);
    if (ref_mode == rtdc_pkg::MODE_INT) begin
      code_y = rtdc_pkg::Y_W'(code_mag) << rtdc_pkg::GAIN_SHIFT;
    end else begin
      code_y = rtdc_pkg::Y_W'(code_mag) * rtdc_pkg::Y_W'(rtdc_pkg::GAIN_EXT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_dvd       <= {code_y, rtdc_pkg::RFRAC_W'(0)};
      a_side.mode <= ref_mode;
      a_side.neg  <= code_neg;
    end
  end

  rtdc_div_pipe #(
    .N       (rtdc_pkg::RDIV_W),
    .DIVISOR (CODE_FULL_SCALE),
    .DV_W    (FS_W),
    .STEPS   (rtdc_pkg::RDIV_STEPS),
    .SIDE_W  ($bits(rtdc_pkg::rdiv_side_t))
  ) u_rdiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (advance),
    .in_valid  (a_valid),
    .in_dvd    (a_dvd),
    .in_side   (a_side),
    .out_valid (rd_valid),
    .out_quo   (rd_quo),
    .out_side  (rd_side)
  );

  // Signed resistance, less the lead offset in external-reference mode.
  always_comb begin
    r_mag    = $signed(RSW'(rd_quo[QW-1:0]));
    r_signed = rd_side.neg ? -r_mag : r_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_mode <= rd_side.mode;
      if (rd_side.mode == rtdc_pkg::MODE_INT) begin
        c_r <= r_signed;
      end else begin
        c_r <= r_signed - RSW'(rtdc_pkg::R_OFFSET);
      end
    end
  end

  // Scaled discriminant.
  assign dn_prod = c_r * rtdc_pkg::DN_SLOPE;
  assign dn_val  = rtdc_pkg::DN_BASE - rtdc_pkg::DN_W'(dn_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (advance) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_dn   <= dn_val;
      d_mode <= c_mode;
    end
  end

  // A negative discriminant feeds zero to the root; its result is replaced at the end.
  always_comb begin
    sq_in_side.mode   = d_mode;
    sq_in_side.dn_neg = d_dn[rtdc_pkg::DN_W-1];
    if (sq_in_side.dn_neg) begin
      sq_rad = '0;
    end else begin
      sq_rad = {1'b0, d_dn[rtdc_pkg::DN_W-2:0], rtdc_pkg::SQ_PAD'(0)};
    end
  end

  rtdc_sqrt_pipe #(
    .ITER   (rtdc_pkg::SQ_ITER),
    .STEPS  (rtdc_pkg::SQ_STEPS),
    .SIDE_W ($bits(rtdc_pkg::sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (advance),
    .in_valid  (d_valid),
    .in_rad    (sq_rad),
    .in_side   (sq_in_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Sign and magnitude of the numerator, and the below-minimum test.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (advance) begin
      e_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e_mode        <= sq_side.mode;
      e_side.dn_neg <= sq_side.dn_neg;
      e_side.neg    <= (sq_root > rtdc_pkg::NUM_BASE);
      e_side.below  <= (sq_side.mode == rtdc_pkg::MODE_INT) && !sq_side.dn_neg &&
                       (sq_root > rtdc_pkg::BELOW_LIM);
      if (sq_root > rtdc_pkg::NUM_BASE) begin
        e_mag <= sq_root - rtdc_pkg::NUM_BASE;
      end else begin
        e_mag <= rtdc_pkg::NUM_BASE - sq_root;
      end
    end
  end

  // Hundredths scaling in external-reference mode, then the power-of-two part of the divisor.
  always_comb begin
    mag_ext = rtdc_pkg::SCALE_W'(e_mag);
    if (e_mode == rtdc_pkg::MODE_INT) begin
      scaled = mag_ext;
    end else begin
      scaled = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_dvd  <= scaled[rtdc_pkg::SCALE_W-1:rtdc_pkg::TDIV_SHIFT];
      f_side <= e_side;
    end
  end

  rtdc_div_pipe #(
    .N       (rtdc_pkg::TDIV_W),
    .DIVISOR (rtdc_pkg::DEG_DIV),
    .DV_W    (rtdc_pkg::DEG_DIV_W),
    .STEPS   (rtdc_pkg::TDIV_STEPS),
    .SIDE_W  ($bits(rtdc_pkg::tdiv_side_t))
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (advance),
    .in_valid  (f_valid),
    .in_dvd    (f_dvd),
    .in_side   (f_side),
    .out_valid (td_valid),
    .out_quo   (td_quo),
    .out_side  (td_side)
  );

  // Apply the sign, saturate to 16 bits and override on a negative discriminant.
  always_comb begin
    res.below_minimum = td_side.below;
    res.range_error   = 1'b0;
    if (td_side.dn_neg) begin
      res.temperature   = rtdc_pkg::TEMP_MAX;
      res.range_error   = 1'b1;
      res.below_minimum = 1'b0;
    end else if (td_side.neg) begin
      if (td_quo > rtdc_pkg::NEG_LIMIT) begin
        res.temperature = rtdc_pkg::TEMP_MIN;
        res.range_error = 1'b1;
      end else begin
        res.temperature = $signed(rtdc_pkg::TEMP_W'(-td_quo));
      end
    end else begin
      if (td_quo > rtdc_pkg::POS_LIMIT) begin
        res.temperature = rtdc_pkg::TEMP_MAX;
        res.range_error = 1'b1;
      end else begin
        res.temperature = $signed(td_quo[rtdc_pkg::TEMP_W-1:0]);
      end
    end
  end

  rtdc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (td_valid && advance),
    .push_item (res),
    .full      (buf_full),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_item    (out_item)
  );

  assign m_tdata    = out_item.temperature;
  assign m_tuser[0] = out_item.below_minimum;
  assign m_tuser[1] = out_item.range_error;

  // An accepted transfer always occupies the input stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> a_valid)
    else $error("accepted transfer did not enter the pipeline");

  // A range error only comes with a saturated temperature.
  a_error_saturated: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |->
      ((m_tdata == 16'h7FFF) || (m_tdata == 16'h8000)))
    else $error("range error without saturated temperature");

  // The below-minimum flag implies a reading of -100 degrees or colder.
  a_below_cold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> ($signed(m_tdata) <= -16'sd100))
    else $error("below-minimum flag on a warm reading");

endmodule

>>> hdl/rtdc_div_pipe.sv
module rtdc_div_pipe #(
  parameter int N       = 44,
  parameter int DIVISOR = 32767,
  parameter int DV_W    = 15,
  parameter int STEPS   = 4,
  parameter int SIDE_W  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [N-1:0]      in_dvd,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [N-1:0]      out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int            NST   = N / STEPS;
  localparam logic [DV_W:0] DIV_C = (DV_W + 1)'(DIVISOR);

  logic              vld  [NST];
  logic [N-1:0]      word [NST];
  logic [DV_W-1:0]   rem  [NST];
  logic [SIDE_W-1:0] side [NST];

  // Restoring division by a constant: the dividend shifts out at the top while quotient
  // bits shift in at the bottom, STEPS bits per stage.
  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic              v_in;
    logic [N-1:0]      w_in;
    logic [DV_W-1:0]   r_in;
    logic [SIDE_W-1:0] sd_in;
    logic [N-1:0]      w_out;
    logic [DV_W-1:0]   r_out;

    if (g == 0) begin : g_head
      assign v_in  = in_valid;
      assign w_in  = in_dvd;
      assign r_in  = '0;
      assign sd_in = in_side;
    end else begin : g_body
      assign v_in  = vld[g-1];
      assign w_in  = word[g-1];
      assign r_in  = rem[g-1];
      assign sd_in = side[g-1];
    end

    always_comb begin : step
      logic [DV_W:0]   t;
      logic [N-1:0]    w;
      logic [DV_W-1:0] r;
      w = w_in;
      r = r_in;
      for (int k = 0; k < STEPS; k++) begin
        t = {r, w[N-1]};
        w = {w[N-2:0], 1'b0};
        if (t >= DIV_C) begin
          r    = DV_W'(t - DIV_C);
          w[0] = 1'b1;
        end else begin
          r = t[DV_W-1:0];
        end
      end
      w_out = w;
      r_out = r;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= v_in;
      end
    end

    // Data of the stage.
    always_ff @(posedge clk) begin
      if (adv) begin
        word[g] <= w_out;
        side[g] <= sd_in;
      end
    end

    // The remainder is only needed by a following stage.
    if (g < NST - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[g] <= r_out;
        end
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign out_quo   = word[NST-1];
  assign out_side  = side[NST-1];

endmodule

>>> hdl/rtdc_sqrt_pipe.sv
module rtdc_sqrt_pipe #(
  parameter int ITER   = 56,
  parameter int STEPS  = 4,
  parameter int SIDE_W = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [2*ITER-1:0]   in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [ITER-1:0]     out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int NST = ITER / STEPS;

  logic              vld  [NST];
  logic [ITER-1:0]   root [NST];
  logic [ITER+1:0]   rem  [NST];
  logic [2*ITER-1:0] rad  [NST];
  logic [SIDE_W-1:0] side [NST];

  // Bit-pair restoring square root, STEPS root bits per stage.
  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic              v_in;
    logic [ITER-1:0]   q_in;
    logic [ITER+1:0]   r_in;
    logic [2*ITER-1:0] a_in;
    logic [SIDE_W-1:0] sd_in;
    logic [ITER-1:0]   q_out;
    logic [ITER+1:0]   r_out;
    logic [2*ITER-1:0] a_out;

    if (g == 0) begin : g_head
      assign v_in  = in_valid;
      assign q_in  = '0;
      assign r_in  = '0;
      assign a_in  = in_rad;
      assign sd_in = in_side;
    end else begin : g_body
      assign v_in  = vld[g-1];
      assign q_in  = root[g-1];
      assign r_in  = rem[g-1];
      assign a_in  = rad[g-1];
      assign sd_in = side[g-1];
    end

    always_comb begin : step
      logic [ITER+3:0]   t;
      logic [ITER+1:0]   trial;
      logic [ITER-1:0]   q;
      logic [ITER+1:0]   r;
      logic [2*ITER-1:0] a;
      q = q_in;
      r = r_in;
      a = a_in;
      for (int k = 0; k < STEPS; k++) begin
        t     = {r, a[2*ITER-1:2*ITER-2]};
        a     = {a[2*ITER-3:0], 2'b00};
        trial = {q, 2'b01};
        if (t >= (ITER + 4)'(trial)) begin
          r = (ITER + 2)'(t - (ITER + 4)'(trial));
          q = {q[ITER-2:0], 1'b1};
        end else begin
          r = t[ITER+1:0];
          q = {q[ITER-2:0], 1'b0};
        end
      end
      q_out = q;
      r_out = r;
      a_out = a;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= v_in;
      end
    end

    // Data of the stage.
    always_ff @(posedge clk) begin
      if (adv) begin
        root[g] <= q_out;
        side[g] <= sd_in;
      end
    end

    // Partial remainder and remaining radicand are only needed by a following stage.
    if (g < NST - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[g] <= r_out;
          rad[g] <= a_out;
        end
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign out_root  = root[NST-1];
  assign out_side  = side[NST-1];

endmodule

>>> hdl/rtdc_out_buf.sv
module rtdc_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rtdc_pkg::res_t     push_item,
  output logic               full,
  output logic               m_valid,
  input  logic               m_ready,
  output rtdc_pkg::res_t     m_item
);

  logic [1:0]     count;
  logic [1:0]     count_next;
  rtdc_pkg::res_t head;
  rtdc_pkg::res_t tail;
  logic           pop;

  assign pop     = m_valid && m_ready;
  assign m_valid = (count != 2'd0);
  assign full    = (count == 2'd2);
  assign m_item  = head;

  // Occupancy of the two entries.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // The head entry is presented on the port; the tail entry catches a result while it waits.
  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      head <= push_item;
    end else if (pop && (count == 2'd2)) begin
      head <= tail;
    end
    if (push && (((count == 2'd1) && !pop) || ((count == 2'd2) && pop))) begin
      tail <= push_item;
    end
  end

endmodule
